>>> hdl/psb_pkg.sv
package psb_pkg;

  // Field widths
  localparam int MS_W       = 10;
  localparam int ADC_W      = 10;
  localparam int DUTY_W     = 8;
  localparam int CH_W       = 3;
  localparam int HOLD_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Sample slots: slot 0 battery, slot 5 board temperature
  localparam int SAMPLE_CHANNELS = 6;
  localparam int SLOT_BATTERY    = 0;
  localparam int SLOT_TEMP       = 5;

  localparam int HOLD_SECONDS_DEF = 4;

  // Timing windows in milliseconds
  localparam logic [MS_W-1:0]  OFF_BLINK_MS   = 10'd20;
  localparam logic [MS_W-1:0]  HOLD_WINDOW_MS = 10'd900;
  localparam logic [MS_W-1:0]  FAN_WINDOW_MS  = 10'd20;
  localparam logic [MS_W-1:0]  ON_LED_MS      = 10'd512;
  localparam logic [MS_W-1:0]  FLAT_LED_MS    = 10'd768;
  localparam logic [7:0]       ON_BLINK_SUB   = 8'd20;
  localparam logic [7:0]       FLAT_BLINK_SUB = 8'd15;

  // Fan law
  localparam logic [DUTY_W-1:0] FAN_FULL   = 8'd255;
  localparam int                FAN_OFFSET = 35;
  localparam logic [HOLD_W-1:0] HOLD_MAX   = 3'd7;

  localparam logic [CFG_DATA_W-1:0] BATTERY_FLOOR_RST = 10'd0;
  localparam logic [CFG_DATA_W-1:0] FAN_THRESHOLD_RST = 10'd540;

  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_FLAT = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    CUE_NONE       = 2'd0,
    CUE_POWER_UP   = 2'd1,
    CUE_POWER_DOWN = 2'd2,
    CUE_ALERT      = 2'd3
  } cue_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BATTERY_FLOOR = 2'd0,
    CFG_FAN_THRESHOLD = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] battery_floor;
    logic [CFG_DATA_W-1:0] fan_threshold;
  } cfg_t;

  typedef struct packed {
    logic [MS_W-1:0]  ms_phase;
    logic             button_pressed;
    logic             shutdown_request;
    logic [ADC_W-1:0] adc_sample;
    logic [ADC_W-1:0] battery_recheck;
  } item_t;

  typedef struct packed {
    logic [1:0]        power_mode;
    logic              regulators_on;
    logic [DUTY_W-1:0] fan_duty;
    logic              red_led;
    logic [1:0]        sounder_cue;
  } result_t;

endpackage

>>> hdl/psb_if.sv
interface psb_in_if;
  logic                       valid;
  logic                       ready;
  logic [psb_pkg::MS_W-1:0]   ms_phase;
  logic                       button_pressed;
  logic                       shutdown_request;
  logic [psb_pkg::ADC_W-1:0]  adc_sample;
  logic [psb_pkg::ADC_W-1:0]  battery_recheck;

  modport source (output valid, ms_phase, button_pressed, shutdown_request, adc_sample,
                  battery_recheck, input ready);
  modport sink (input valid, ms_phase, button_pressed, shutdown_request, adc_sample,
                battery_recheck, output ready);
endinterface

interface psb_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  power_mode;
  logic                        regulators_on;
  logic [psb_pkg::DUTY_W-1:0]  fan_duty;
  logic                        red_led;
  logic [1:0]                  sounder_cue;

  modport source (output valid, power_mode, regulators_on, fan_duty, red_led, sounder_cue,
                  input ready);
  modport sink (input valid, power_mode, regulators_on, fan_duty, red_led, sounder_cue,
                output ready);
endinterface

interface psb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [psb_pkg::CFG_IDX_W-1:0]    reg_index;
  logic [psb_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> hdl/psb_cfg_regs.sv
module psb_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  psb_cfg_if.sink       cfg_chan,
  output psb_pkg::cfg_t cfg
);
  import psb_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_chan.ready = 1'b1;
  assign cfg = cfg_r;

  // Decode the write request by register index; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        CFG_BATTERY_FLOOR: cfg_nxt.battery_floor = cfg_chan.wdata;
        CFG_FAN_THRESHOLD: cfg_nxt.fan_threshold = cfg_chan.wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.battery_floor <= BATTERY_FLOOR_RST;
      cfg_r.fan_threshold <= FAN_THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> hdl/psb_core.sv
module psb_core #(
  parameter int HOLD_SECONDS = psb_pkg::HOLD_SECONDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  psb_pkg::item_t   item,
  input  psb_pkg::cfg_t    cfg,
  output psb_pkg::result_t result
);
  import psb_pkg::*;

  localparam logic [HOLD_W-1:0] HOLD_LIMIT = HOLD_W'(HOLD_SECONDS);

  mode_t             mode_r, mode_nxt;
  logic [CH_W-1:0]   chan_r, chan_nxt;
  logic [ADC_W-1:0]  store_r   [SAMPLE_CHANNELS];
  logic [ADC_W-1:0]  store_nxt [SAMPLE_CHANNELS];
  logic [HOLD_W-1:0] hold_cnt_r, hold_cnt_nxt;
  logic              hold_smp_r, hold_smp_nxt;
  logic              held_r, held_nxt;
  logic              pend_r, pend_nxt;
  logic              fan_upd_r, fan_upd_nxt;
  logic              led_r, led_nxt;
  logic [DUTY_W-1:0] duty_r, duty_nxt;
  logic              regs_r, regs_nxt;
  cue_t              cue;

  logic [ADC_W-1:0]  slot0, slot5;
  logic              bat_low, rec_low;
  logic [7:0]        sub;
  logic signed [12:0] diff, fan_t;
  logic [DUTY_W-1:0] fan_duty;

  // Slot values after this request's sample store
  assign slot0 = (chan_r == CH_W'(SLOT_BATTERY)) ? item.adc_sample : store_r[SLOT_BATTERY];
  assign slot5 = (chan_r == CH_W'(SLOT_TEMP)) ? item.adc_sample : store_r[SLOT_TEMP];
  assign bat_low = slot0 < cfg.battery_floor;
  assign rec_low = item.battery_recheck < cfg.battery_floor;
  assign sub = item.ms_phase[7:0];

  // Fan law: (temp - threshold) * 3 + offset, clamped to the duty range
  always_comb begin
    diff  = $signed({3'b000, slot5}) - $signed({3'b000, cfg.fan_threshold});
    fan_t = diff + (diff <<< 1) + 13'(FAN_OFFSET);
    if (fan_t < 0) begin
      fan_duty = '0;
    end else if (fan_t > 13'sd255) begin
      fan_duty = FAN_FULL;
    end else begin
      fan_duty = fan_t[DUTY_W-1:0];
    end
  end

  // Next state for one request
  always_comb begin
    mode_nxt     = mode_r;
    hold_cnt_nxt = hold_cnt_r;
    hold_smp_nxt = hold_smp_r;
    held_nxt     = held_r;
    pend_nxt     = pend_r;
    fan_upd_nxt  = fan_upd_r;
    led_nxt      = led_r;
    duty_nxt     = duty_r;
    regs_nxt     = regs_r;
    cue          = CUE_NONE;
    for (int i = 0; i < SAMPLE_CHANNELS; i++) begin
      store_nxt[i] = store_r[i];
    end

    // Store the sample and advance the round robin
    if (chan_r < CH_W'(SAMPLE_CHANNELS)) begin
      store_nxt[chan_r] = item.adc_sample;
    end
    if (chan_r >= CH_W'(SAMPLE_CHANNELS - 1)) begin
      chan_nxt = '0;
    end else begin
      chan_nxt = chan_r + 1'b1;
    end

    unique case (mode_r)
      MODE_OFF: begin
        // Short blink at the start of each frame
        if (led_r) begin
          if (item.ms_phase > OFF_BLINK_MS) led_nxt = 1'b0;
        end else if (item.ms_phase <= OFF_BLINK_MS) begin
          led_nxt = 1'b1;
        end
        if (item.button_pressed) begin
          if (bat_low) store_nxt[SLOT_BATTERY] = item.battery_recheck;
          if (bat_low && rec_low) begin
            mode_nxt = MODE_FLAT;
            cue      = CUE_ALERT;
            regs_nxt = 1'b0;
          end else begin
            mode_nxt    = MODE_ON;
            regs_nxt    = 1'b1;
            duty_nxt    = FAN_FULL;
            fan_upd_nxt = 1'b1;
            cue         = CUE_POWER_UP;
          end
        end
      end
      MODE_ON: begin
        // Sample the button once per frame, count held frames at frame end
        if (item.ms_phase < HOLD_WINDOW_MS) begin
          if (!hold_smp_r) begin
            held_nxt     = item.button_pressed;
            hold_smp_nxt = 1'b1;
          end
        end else if (hold_smp_r) begin
          if (held_r) begin
            if (hold_cnt_r < HOLD_MAX) begin
              hold_cnt_nxt = hold_cnt_r + 1'b1;
              if (hold_cnt_nxt == HOLD_LIMIT) pend_nxt = 1'b1;
            end
          end else begin
            hold_cnt_nxt = '0;
          end
          hold_smp_nxt = 1'b0;
        end

        // Update the fan once per frame
        if (item.ms_phase < FAN_WINDOW_MS) begin
          if (!fan_upd_r) begin
            duty_nxt    = fan_duty;
            fan_upd_nxt = 1'b1;
          end
        end else begin
          fan_upd_nxt = 1'b0;
        end

        // Fast blink in the first half frame
        if (item.ms_phase < ON_LED_MS) begin
          if (led_r) begin
            if (sub > ON_BLINK_SUB) led_nxt = 1'b0;
          end else if (sub <= ON_BLINK_SUB) begin
            led_nxt = 1'b1;
          end
        end

        // Recheck the battery
        if (bat_low) store_nxt[SLOT_BATTERY] = item.battery_recheck;
        if (bat_low && rec_low) begin
          mode_nxt = MODE_FLAT;
          cue      = CUE_ALERT;
          regs_nxt = 1'b0;
        end

        // Shutdown wins over a flat battery
        if (pend_nxt || item.shutdown_request) begin
          cue      = CUE_POWER_DOWN;
          regs_nxt = 1'b0;
          mode_nxt = MODE_OFF;
          pend_nxt = 1'b0;
        end
      end
      MODE_FLAT: begin
        // Triple flash
        if (item.ms_phase < FLAT_LED_MS) begin
          if (led_r) begin
            if (sub > FLAT_BLINK_SUB) led_nxt = 1'b0;
          end else if (sub <= FLAT_BLINK_SUB) begin
            led_nxt = 1'b1;
          end
        end
      end
      default: begin
        mode_nxt = mode_r;
      end
    endcase

    result.power_mode    = mode_nxt;
    result.regulators_on = regs_nxt;
    result.fan_duty      = duty_nxt;
    result.red_led       = led_nxt;
    result.sounder_cue   = cue;
  end

  // Commit state when a request is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_OFF;
      chan_r     <= '0;
      hold_cnt_r <= '0;
      hold_smp_r <= 1'b0;
      held_r     <= 1'b0;
      pend_r     <= 1'b0;
      fan_upd_r  <= 1'b0;
      led_r      <= 1'b0;
      duty_r     <= '0;
      regs_r     <= 1'b0;
      for (int i = 0; i < SAMPLE_CHANNELS; i++) begin
        store_r[i] <= '0;
      end
    end else if (fire) begin
      mode_r     <= mode_nxt;
      chan_r     <= chan_nxt;
      hold_cnt_r <= hold_cnt_nxt;
      hold_smp_r <= hold_smp_nxt;
      held_r     <= held_nxt;
      pend_r     <= pend_nxt;
      fan_upd_r  <= fan_upd_nxt;
      led_r      <= led_nxt;
      duty_r     <= duty_nxt;
      regs_r     <= regs_nxt;
      for (int i = 0; i < SAMPLE_CHANNELS; i++) begin
        store_r[i] <= store_nxt[i];
      end
    end
  end

endmodule

>>> hdl/power_board_supervisor_unit.sv
// Power board supervisor.
// in_chan carries one supervisory request per accepted valid/ready handshake:
// the millisecond phase, button and host shutdown levels, the round-robin ADC
// sample and a fresh battery reading. out_chan returns exactly one result per
// request: power mode, regulator enable, fan duty, LED level and sounder cue.
// cfg_chan writes battery_floor (index 0) and fan_threshold (index 1); it is
// always ready; the user writes it only while no request is in flight.
// The block does not enforce this. Throughput: one request per cycle,
// sustained while out_chan is ready. A request is held in the input register,
// where the mode logic runs against the state registers, and its result is then
// loaded into the output register. State is committed at the same edge that
// loads the result, so the next request sees it without a bubble.
// When out_chan stalls, the output register holds its result and the input
// register can still take one more request; in_chan.ready then drops until the
// receiver takes the result.
// Reset (rst_n low, synchronous): mode off, regulators off, fan duty 0, LED off,
// all sample slots and counters zero, battery_floor 0, fan_threshold 540,
// both pipeline registers empty.
module power_board_supervisor_unit #(
  parameter int HOLD_SECONDS = psb_pkg::HOLD_SECONDS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  psb_in_if.sink   in_chan,
  psb_out_if.source out_chan,
  psb_cfg_if.sink  cfg_chan
);
  import psb_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r, item_vld_nxt;
  result_t result, out_data_r;
  logic    out_vld_r, out_vld_nxt;
  logic    advance, fire, in_take;

  psb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg      (cfg)
  );

  psb_core #(
    .HOLD_SECONDS (HOLD_SECONDS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Pipeline handshake
  assign advance        = !out_vld_r || out_chan.ready;
  assign fire           = item_vld_r && advance;
  assign in_chan.ready  = !item_vld_r || advance;
  assign in_take        = in_chan.valid && in_chan.ready;

  always_comb begin
    if (in_take) begin
      item_vld_nxt = 1'b1;
    end else if (fire) begin
      item_vld_nxt = 1'b0;
    end else begin
      item_vld_nxt = item_vld_r;
    end
    out_vld_nxt = advance ? item_vld_r : out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Capture the request and the result payloads
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.ms_phase         <= in_chan.ms_phase;
      item_r.button_pressed   <= in_chan.button_pressed;
      item_r.shutdown_request <= in_chan.shutdown_request;
      item_r.adc_sample       <= in_chan.adc_sample;
      item_r.battery_recheck  <= in_chan.battery_recheck;
    end
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.power_mode    = out_data_r.power_mode;
  assign out_chan.regulators_on = out_data_r.regulators_on;
  assign out_chan.fan_duty      = out_data_r.fan_duty;
  assign out_chan.red_led       = out_data_r.red_led;
  assign out_chan.sounder_cue   = out_data_r.sounder_cue;

endmodule
